// File: hdl/ufp_pkg.sv
package ufp_pkg;

    localparam logic [7:0] SYNC_CHAR_1 = 8'hB5;
    localparam logic [7:0] SYNC_CHAR_2 = 8'h62;

    localparam logic [7:0] CLASS_NAV = 8'h01;
    localparam logic [7:0] CLASS_RXM = 8'h02;
    localparam logic [7:0] CLASS_INF = 8'h04;
    localparam logic [7:0] CLASS_ACK = 8'h05;
    localparam logic [7:0] CLASS_CFG = 8'h06;
    localparam logic [7:0] CLASS_UPD = 8'h09;
    localparam logic [7:0] CLASS_MON = 8'h0A;
    localparam logic [7:0] CLASS_AID = 8'h0B;
    localparam logic [7:0] CLASS_TIM = 8'h0D;

    localparam logic [10:0] MAX_LEN_RESET = 11'd1024;
    localparam logic [10:0] MSG_LEN_SAT   = 11'h7FF;

    typedef enum logic [3:0] {
        ST_HUNT    = 4'd0,
        ST_SYNC1   = 4'd1,
        ST_CLASS   = 4'd2,
        ST_ID      = 4'd3,
        ST_LEN0    = 4'd4,
        ST_LEN1    = 4'd5,
        ST_PAYLOAD = 4'd6,
        ST_CKA     = 4'd7,
        ST_CKB     = 4'd8
    } t_state;

    // Frame context carried from one byte to the next.
    typedef struct packed {
        t_state      state;
        logic [7:0]  sum_a;
        logic [7:0]  sum_b;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] frame_length;
        logic [10:0] bytes_taken;
    } t_ctx;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [9:0]  payload_index;
        logic        frame_done;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [10:0] msg_length;
        logic        checksum_error;
        logic        length_error;
    } t_result;

    function automatic logic known_class(input logic [7:0] code);
        logic hit;
        case (code)
            CLASS_NAV, CLASS_RXM, CLASS_INF, CLASS_ACK, CLASS_CFG,
            CLASS_UPD, CLASS_MON, CLASS_AID, CLASS_TIM: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// File: hdl/ubx_frame_parser_unit.sv
// Byte-stream frame parser with an 8-bit Fletcher check.
//
// Input channel: one received byte per request on i_rx_byte, qualified by
// i_in_valid and held off by o_in_stall. Output channel: one result per
// input byte, qualified by o_out_valid and held off by i_out_stall. Each
// result carries the payload byte and index (when the byte is payload),
// the current class, id and saturated length, and the frame done, checksum
// error and length error flags.
// The result of an accepted byte is registered and appears in the cycle
// after it is accepted. Throughput is one byte per cycle while o_in_stall
// is low; the only loop, the frame context register, updates once per byte.
// A valid result stays put while i_out_stall is high, and o_in_stall
// is raised only while a result is held, so no byte is lost.
// The user must write the length limit through i_cfg_we and i_cfg_data
// only while idle (not enforced); the smaller of it and MAX_PAYLOAD applies.
// A synchronous reset clears the context to hunting for the first sync
// byte, sets the limit to 1024 and drops any held result. No clearing pass.
module ubx_frame_parser_unit #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [9:0]  o_payload_index,
    output logic        o_frame_done,
    output logic [7:0]  o_msg_class,
    output logic [7:0]  o_msg_id,
    output logic [10:0] o_msg_length,
    output logic        o_checksum_error,
    output logic        o_length_error
);

    ufp_pkg::t_ctx    r_ctx;
    ufp_pkg::t_ctx    n_ctx;
    ufp_pkg::t_result r_res;
    ufp_pkg::t_result n_res;
    logic             r_out_valid;
    logic [10:0]      r_max_len;
    logic             accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    ufp_step #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_step (
        .i_ctx     (r_ctx),
        .i_rx_byte (i_rx_byte),
        .i_max_len (r_max_len),
        .o_ctx     (n_ctx),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= ufp_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.state        <= ufp_pkg::ST_HUNT;
            r_ctx.sum_a        <= 8'd0;
            r_ctx.sum_b        <= 8'd0;
            r_ctx.frame_class  <= 8'd0;
            r_ctx.frame_id     <= 8'd0;
            r_ctx.frame_length <= 16'd0;
            r_ctx.bytes_taken  <= 11'd0;
        end else if (accept) begin
            r_ctx <= n_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_payload_valid  = r_res.payload_valid;
    assign o_payload_byte   = r_res.payload_byte;
    assign o_payload_index  = r_res.payload_index;
    assign o_frame_done     = r_res.frame_done;
    assign o_msg_class      = r_res.msg_class;
    assign o_msg_id         = r_res.msg_id;
    assign o_msg_length     = r_res.msg_length;
    assign o_checksum_error = r_res.checksum_error;
    assign o_length_error   = r_res.length_error;

endmodule

// File: hdl/ufp_step.sv
module ufp_step #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  ufp_pkg::t_ctx    i_ctx,
    input  logic [7:0]       i_rx_byte,
    input  logic [10:0]      i_max_len,
    output ufp_pkg::t_ctx    o_ctx,
    output ufp_pkg::t_result o_res
);

    localparam logic [15:0] MaxPayloadLen = 16'(MAX_PAYLOAD);

    ufp_pkg::t_state n_state;
    logic [7:0]      sum_a_fold;
    logic [7:0]      sum_b_fold;
    logic [15:0]     len_full;
    logic [10:0]     taken_inc;
    logic            len_over;

    assign sum_a_fold = i_ctx.sum_a + i_rx_byte;
    assign sum_b_fold = i_ctx.sum_b + sum_a_fold;
    assign len_full   = {i_rx_byte, i_ctx.frame_length[7:0]};
    assign taken_inc  = i_ctx.bytes_taken + 11'd1;
    // The limit in force is the smaller of the register and the build limit.
    assign len_over   = (len_full > {5'd0, i_max_len}) || (len_full > MaxPayloadLen);

    always_comb begin
        case (i_ctx.state)
            ufp_pkg::ST_HUNT: begin
                n_state = (i_rx_byte == ufp_pkg::SYNC_CHAR_1) ? ufp_pkg::ST_SYNC1
                                                              : ufp_pkg::ST_HUNT;
            end
            ufp_pkg::ST_SYNC1: begin
                n_state = (i_rx_byte == ufp_pkg::SYNC_CHAR_2) ? ufp_pkg::ST_CLASS
                                                              : ufp_pkg::ST_HUNT;
            end
            ufp_pkg::ST_CLASS: begin
                n_state = ufp_pkg::known_class(i_rx_byte) ? ufp_pkg::ST_ID
                                                          : ufp_pkg::ST_HUNT;
            end
            ufp_pkg::ST_ID:   n_state = ufp_pkg::ST_LEN0;
            ufp_pkg::ST_LEN0: n_state = ufp_pkg::ST_LEN1;
            ufp_pkg::ST_LEN1: begin
                if (len_over) begin
                    n_state = ufp_pkg::ST_HUNT;
                end else if (len_full == 16'd0) begin
                    n_state = ufp_pkg::ST_CKA;
                end else begin
                    n_state = ufp_pkg::ST_PAYLOAD;
                end
            end
            ufp_pkg::ST_PAYLOAD: begin
                n_state = ({5'd0, taken_inc} >= i_ctx.frame_length) ? ufp_pkg::ST_CKA
                                                                    : ufp_pkg::ST_PAYLOAD;
            end
            ufp_pkg::ST_CKA: begin
                n_state = (i_rx_byte == i_ctx.sum_a) ? ufp_pkg::ST_CKB : ufp_pkg::ST_HUNT;
            end
            ufp_pkg::ST_CKB: n_state = ufp_pkg::ST_HUNT;
            default:         n_state = ufp_pkg::ST_HUNT;
        endcase
    end

    always_comb begin
        o_ctx       = i_ctx;
        o_ctx.state = n_state;
        o_res       = '0;
        case (i_ctx.state)
            ufp_pkg::ST_HUNT: begin
                o_ctx.sum_a       = 8'd0;
                o_ctx.sum_b       = 8'd0;
                o_ctx.bytes_taken = 11'd0;
            end
            ufp_pkg::ST_CLASS: begin
                if (ufp_pkg::known_class(i_rx_byte)) begin
                    o_ctx.sum_a       = sum_a_fold;
                    o_ctx.sum_b       = sum_b_fold;
                    o_ctx.frame_class = i_rx_byte;
                end
            end
            ufp_pkg::ST_ID: begin
                o_ctx.sum_a    = sum_a_fold;
                o_ctx.sum_b    = sum_b_fold;
                o_ctx.frame_id = i_rx_byte;
            end
            ufp_pkg::ST_LEN0: begin
                o_ctx.sum_a        = sum_a_fold;
                o_ctx.sum_b        = sum_b_fold;
                o_ctx.frame_length = {8'd0, i_rx_byte};
            end
            ufp_pkg::ST_LEN1: begin
                o_ctx.sum_a        = sum_a_fold;
                o_ctx.sum_b        = sum_b_fold;
                o_ctx.frame_length = len_full;
                o_ctx.bytes_taken  = 11'd0;
                o_res.length_error = len_over;
            end
            ufp_pkg::ST_PAYLOAD: begin
                o_ctx.sum_a         = sum_a_fold;
                o_ctx.sum_b         = sum_b_fold;
                o_ctx.bytes_taken   = taken_inc;
                o_res.payload_valid = 1'b1;
                o_res.payload_byte  = i_rx_byte;
                o_res.payload_index = i_ctx.bytes_taken[9:0];
            end
            ufp_pkg::ST_CKA: begin
                o_res.checksum_error = (i_rx_byte != i_ctx.sum_a);
            end
            ufp_pkg::ST_CKB: begin
                o_res.frame_done     = (i_rx_byte == i_ctx.sum_b);
                o_res.checksum_error = (i_rx_byte != i_ctx.sum_b);
            end
            default: begin
            end
        endcase
        o_res.msg_class  = o_ctx.frame_class;
        o_res.msg_id     = o_ctx.frame_id;
        o_res.msg_length = (o_ctx.frame_length[15:11] != 5'd0) ? ufp_pkg::MSG_LEN_SAT
                                                               : o_ctx.frame_length[10:0];
    end

endmodule

// File: hdl/ufp_checker.sv
module ufp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_payload_valid,
    input logic [9:0]  o_payload_index,
    input logic [7:0]  o_payload_byte,
    input logic        o_frame_done,
    input logic [10:0] o_msg_length,
    input logic        o_checksum_error,
    input logic        o_length_error
);

    // A byte has exactly one role, so at most one outcome flag is set.
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_payload_valid, o_frame_done,
                                  o_checksum_error, o_length_error}))
        else $error("more than one outcome flag in a result");

    // A payload byte always lies inside the declared length.
    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_payload_valid) |-> ({1'b0, o_payload_index} < o_msg_length))
        else $error("payload index beyond the declared length");

    // An oversize length can never be zero.
    a_len_err_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_length_error) |-> (o_msg_length != 11'd0))
        else $error("length error with a zero length");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_payload_byte)
                                          && $stable(o_msg_length)))
        else $error("held result changed under stall");

endmodule

bind ubx_frame_parser_unit ufp_checker u_ufp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_payload_valid  (o_payload_valid),
    .o_payload_index  (o_payload_index),
    .o_payload_byte   (o_payload_byte),
    .o_frame_done     (o_frame_done),
    .o_msg_length     (o_msg_length),
    .o_checksum_error (o_checksum_error),
    .o_length_error   (o_length_error)
);

// File: bench/ubx_frame_parser_checker.sv
module ubx_frame_parser_checker #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [10:0]      i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  ufp_pkg::t_result i_result,
    output int               o_mismatches,
    output int               o_pending
);

    ufp_pkg::t_ctx    ctx;
    logic [10:0]      len_limit;
    ufp_pkg::t_result awaited_results[$];
    int               mismatches = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    task automatic fold_into_sum(input logic [7:0] b);
        ctx.sum_a = ctx.sum_a + b;
        ctx.sum_b = ctx.sum_b + ctx.sum_a;
    endtask

    // Moves the parser state on by one received byte and builds the result it yields.
    task automatic advance_parser(input logic [7:0] b, output ufp_pkg::t_result r);
        int cap;
        r = '0;
        case (ctx.state)
            ufp_pkg::ST_HUNT: begin
                ctx.sum_a       = '0;
                ctx.sum_b       = '0;
                ctx.bytes_taken = '0;
                if (b == ufp_pkg::SYNC_CHAR_1) ctx.state = ufp_pkg::ST_SYNC1;
            end
            ufp_pkg::ST_SYNC1: begin
                if (b == ufp_pkg::SYNC_CHAR_2) ctx.state = ufp_pkg::ST_CLASS;
                else ctx.state = ufp_pkg::ST_HUNT;
            end
            ufp_pkg::ST_CLASS: begin
                case (b)
                    ufp_pkg::CLASS_NAV, ufp_pkg::CLASS_RXM, ufp_pkg::CLASS_INF,
                    ufp_pkg::CLASS_ACK, ufp_pkg::CLASS_CFG, ufp_pkg::CLASS_UPD,
                    ufp_pkg::CLASS_MON, ufp_pkg::CLASS_AID, ufp_pkg::CLASS_TIM: begin
                        fold_into_sum(b);
                        ctx.frame_class = b;
                        ctx.state       = ufp_pkg::ST_ID;
                    end
                    default: ctx.state = ufp_pkg::ST_HUNT;
                endcase
            end
            ufp_pkg::ST_ID: begin
                fold_into_sum(b);
                ctx.frame_id = b;
                ctx.state    = ufp_pkg::ST_LEN0;
            end
            ufp_pkg::ST_LEN0: begin
                fold_into_sum(b);
                ctx.frame_length = {8'h00, b};
                ctx.state        = ufp_pkg::ST_LEN1;
            end
            ufp_pkg::ST_LEN1: begin
                fold_into_sum(b);
                ctx.frame_length[15:8] = b;
                ctx.bytes_taken        = '0;
                cap = (int'(len_limit) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len_limit);
                if (int'(ctx.frame_length) > cap) begin
                    r.length_error = 1'b1;
                    ctx.state      = ufp_pkg::ST_HUNT;
                end else if (ctx.frame_length == 16'd0) begin
                    ctx.state = ufp_pkg::ST_CKA;
                end else begin
                    ctx.state = ufp_pkg::ST_PAYLOAD;
                end
            end
            ufp_pkg::ST_PAYLOAD: begin
                fold_into_sum(b);
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_index = ctx.bytes_taken[9:0];
                ctx.bytes_taken = ctx.bytes_taken + 11'd1;
                if ({5'b0, ctx.bytes_taken} >= ctx.frame_length) ctx.state = ufp_pkg::ST_CKA;
            end
            ufp_pkg::ST_CKA: begin
                if (b == ctx.sum_a) begin
                    ctx.state = ufp_pkg::ST_CKB;
                end else begin
                    r.checksum_error = 1'b1;
                    ctx.state        = ufp_pkg::ST_HUNT;
                end
            end
            ufp_pkg::ST_CKB: begin
                if (b == ctx.sum_b) r.frame_done = 1'b1;
                else r.checksum_error = 1'b1;
                ctx.state = ufp_pkg::ST_HUNT;
            end
            default: ctx.state = ufp_pkg::ST_HUNT;
        endcase
        r.msg_class  = ctx.frame_class;
        r.msg_id     = ctx.frame_id;
        r.msg_length = (ctx.frame_length > 16'h07FF) ? ufp_pkg::MSG_LEN_SAT
                                                     : ctx.frame_length[10:0];
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        ufp_pkg::t_result want;
        ufp_pkg::t_result fresh;
        if (!i_rst_n) begin
            ctx       = '0;
            ctx.state = ufp_pkg::ST_HUNT;
            len_limit = ufp_pkg::MAX_LEN_RESET;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) len_limit = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result arrived with none expected", $time);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("payload_valid", 16'(want.payload_valid),
                                16'(i_result.payload_valid));
                    check_field("payload_byte", 16'(want.payload_byte),
                                16'(i_result.payload_byte));
                    check_field("payload_index", 16'(want.payload_index),
                                16'(i_result.payload_index));
                    check_field("frame_done", 16'(want.frame_done),
                                16'(i_result.frame_done));
                    check_field("msg_class", 16'(want.msg_class),
                                16'(i_result.msg_class));
                    check_field("msg_id", 16'(want.msg_id), 16'(i_result.msg_id));
                    check_field("msg_length", 16'(want.msg_length),
                                16'(i_result.msg_length));
                    check_field("checksum_error", 16'(want.checksum_error),
                                16'(i_result.checksum_error));
                    check_field("length_error", 16'(want.length_error),
                                16'(i_result.length_error));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_parser(i_rx_byte, fresh);
                awaited_results.push_back(fresh);
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= awaited_results.size();
    end

endmodule

// File: bench/ubx_frame_parser_unit_tb.sv
module ubx_frame_parser_unit_tb;

    localparam int PAYLOAD_CAP = 1024;
    localparam int QUIET_LIMIT = 2000;
    localparam int PER_LIMIT   = 90;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_CKA,
        FLAW_BAD_CKB,
        FLAW_CUT
    } t_frame_flaw;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [10:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic [7:0]  rx_byte  = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic        frame_done;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [10:0] msg_length;
    logic        checksum_error;
    logic        length_error;

    int mismatches;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int lim_eff       = 1024;
    int bytes_sent    = 0;
    int frames_sent   = 0;
    int quiet_cycles  = 0;

    logic [10:0] limit_plan [6] = '{11'd16, 11'd0, 11'd2047, 11'd1, 11'd40, 11'd1024};

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ubx_frame_parser_unit #(
        .MAX_PAYLOAD(PAYLOAD_CAP)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_payload_valid  (payload_valid),
        .o_payload_byte   (payload_byte),
        .o_payload_index  (payload_index),
        .o_frame_done     (frame_done),
        .o_msg_class      (msg_class),
        .o_msg_id         (msg_id),
        .o_msg_length     (msg_length),
        .o_checksum_error (checksum_error),
        .o_length_error   (length_error)
    );

    ubx_frame_parser_checker #(
        .MAX_PAYLOAD(PAYLOAD_CAP)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_rx_byte    (rx_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_result     ({payload_valid, payload_byte, payload_index, frame_done, msg_class,
                        msg_id, msg_length, checksum_error, length_error}),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // The run is stuck if no request moves on either side for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ubx_frame_parser_unit_tb: done, errors");
            $finish;
        end
    end

    task automatic put_rx_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // Sends sync, header, payload and check bytes; a cut frame sends at most eight payload bytes and no check bytes.
    task automatic put_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input t_frame_flaw flaw);
        logic [7:0] head [4];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] data;
        logic [7:0] flip;
        int         body;
        head = '{cls, id, len[7:0], len[15:8]};
        ck_a = '0;
        ck_b = '0;
        flip = 8'h01 << $urandom_range(0, 7);
        put_rx_byte(ufp_pkg::SYNC_CHAR_1);
        put_rx_byte(ufp_pkg::SYNC_CHAR_2);
        for (int i = 0; i < 4; i++) begin
            ck_a = ck_a + head[i];
            ck_b = ck_b + ck_a;
            put_rx_byte(head[i]);
        end
        if (flaw == FLAW_CUT) body = $urandom_range(0, (len > 8) ? 8 : len);
        else body = len;
        for (int i = 0; i < body; i++) begin
            data = 8'($urandom_range(0, 255));
            ck_a = ck_a + data;
            ck_b = ck_b + ck_a;
            put_rx_byte(data);
        end
        if (flaw == FLAW_CUT) return;
        put_rx_byte((flaw == FLAW_BAD_CKA) ? (ck_a ^ flip) : ck_a);
        put_rx_byte((flaw == FLAW_BAD_CKB) ? (ck_b ^ flip) : ck_b);
        frames_sent++;
    endtask

    task automatic put_random_frame();
        logic [7:0]  cls;
        logic [15:0] len;
        t_frame_flaw flaw;
        int          pick;
        case ($urandom_range(0, 8))
            0: cls = ufp_pkg::CLASS_NAV;
            1: cls = ufp_pkg::CLASS_RXM;
            2: cls = ufp_pkg::CLASS_INF;
            3: cls = ufp_pkg::CLASS_ACK;
            4: cls = ufp_pkg::CLASS_CFG;
            5: cls = ufp_pkg::CLASS_UPD;
            6: cls = ufp_pkg::CLASS_MON;
            7: cls = ufp_pkg::CLASS_AID;
            default: cls = ufp_pkg::CLASS_TIM;
        endcase
        pick = $urandom_range(0, 99);
        flaw = FLAW_NONE;
        if (pick < 72) begin
            len = 16'($urandom_range(0, (lim_eff < 12) ? lim_eff : 12));
        end else if (pick < 82) begin
            len = 16'($urandom_range(0, (lim_eff < 80) ? lim_eff : 80));
        end else if (pick < 88 && lim_eff <= 64) begin
            len = 16'(lim_eff);
        end else if (pick < 94) begin
            len  = 16'(lim_eff + 1 + int'($urandom_range(0, 3)));
            flaw = FLAW_CUT;
        end else begin
            len  = 16'($urandom_range(lim_eff + 1, 65535));
            flaw = FLAW_CUT;
        end
        if (flaw == FLAW_NONE) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) flaw = FLAW_BAD_CKA;
            else if (pick < 16) flaw = FLAW_BAD_CKB;
            else if (pick < 22) flaw = FLAW_CUT;
        end
        put_frame(cls, 8'($urandom_range(0, 255)), len, flaw);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial begin
        logic [7:0] b;
        int         target;
        int         kind;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset limit: noise, a repeated first sync byte,
        // a one-byte frame, a zero-length frame and an unknown class.
        put_rx_byte(8'h00);
        put_rx_byte(8'hFF);
        put_rx_byte(ufp_pkg::SYNC_CHAR_1);
        put_rx_byte(ufp_pkg::SYNC_CHAR_1);
        put_rx_byte(ufp_pkg::SYNC_CHAR_2);
        put_frame(ufp_pkg::CLASS_NAV, 8'hFF, 16'd1, FLAW_NONE);
        put_frame(ufp_pkg::CLASS_TIM, 8'h00, 16'd0, FLAW_NONE);
        put_rx_byte(ufp_pkg::SYNC_CHAR_1);
        put_rx_byte(ufp_pkg::SYNC_CHAR_2);
        put_rx_byte(8'h03);

        for (int s = 0; s < 6; s++) begin
            case (s / 2)
                0: begin
                    send_idle_pct = 23;
                    recv_idle_pct = 50;
                end
                1: begin
                    send_idle_pct = 50;
                    recv_idle_pct = 23;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            drain_results();
            cfg_we   <= 1'b1;
            cfg_data <= limit_plan[s];
            @(posedge clk);
            cfg_we  <= 1'b0;
            lim_eff = (limit_plan[s] > PAYLOAD_CAP) ? PAYLOAD_CAP : limit_plan[s];
            target  = bytes_sent + PER_LIMIT;
            if (lim_eff == PAYLOAD_CAP && s == 5) begin
                put_frame(ufp_pkg::CLASS_MON, 8'($urandom_range(0, 255)), 16'(PAYLOAD_CAP),
                          FLAW_NONE);
            end
            while (bytes_sent < target) begin
                kind = $urandom_range(0, 99);
                if (kind < 72) begin
                    put_random_frame();
                end else if (kind < 80) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == ufp_pkg::SYNC_CHAR_2) b = ufp_pkg::SYNC_CHAR_1;
                    put_rx_byte(ufp_pkg::SYNC_CHAR_1);
                    put_rx_byte(b);
                end else if (kind < 88) begin
                    put_rx_byte(ufp_pkg::SYNC_CHAR_1);
                    put_rx_byte(ufp_pkg::SYNC_CHAR_2);
                    put_rx_byte(8'($urandom_range(0, 255)));
                end else begin
                    repeat ($urandom_range(1, 4)) put_rx_byte(8'($urandom_range(0, 255)));
                end
            end
        end

        drain_results();
        $display("Covered %0d bytes with %0d complete frames sent, six length limits",
                 bytes_sent, frames_sent);
        $display("and three idle patterns on the two channels.");
        if (mismatches == 0 && pending == 0) begin
            $display("ubx_frame_parser_unit_tb: done, clean");
        end else begin
            $display("ubx_frame_parser_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/ufp_pkg.sv
hdl/ufp_step.sv
hdl/ubx_frame_parser_unit.sv
hdl/ufp_checker.sv
bench/ubx_frame_parser_checker.sv
bench/ubx_frame_parser_unit_tb.sv
